// File: rtl/sws_pkg.sv
// ----------------------------------------------------------------------------
// sws_pkg
// Shared types and constants of the stop-and-wait sender control.
// ----------------------------------------------------------------------------
package sws_pkg;

    localparam int unsigned TimeoutW  = 16;
    localparam int unsigned AttemptsW = 4;
    localparam int unsigned ApbAddrW  = 3;
    localparam int unsigned ApbDataW  = 32;

    localparam logic [TimeoutW-1:0]  TimeoutReset  = 16'd2000;
    localparam logic [AttemptsW-1:0] AttemptsReset = 4'd3;

    // register byte addresses
    localparam logic [ApbAddrW-1:0] AddrTimeout  = 3'd0;
    localparam logic [ApbAddrW-1:0] AddrAttempts = 3'd4;

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_DATA = 2'd1,
        CMD_ACK  = 2'd2,
        CMD_EOF  = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        EV_NONE      = 4'd0,
        EV_FIRST     = 4'd1,
        EV_TIMEOUT   = 4'd2,
        EV_BAD_CHECK = 4'd3,
        EV_WRONG_SEQ = 4'd4,
        EV_ACCEPTED  = 4'd5,
        EV_EOF_ACK   = 4'd6,
        EV_EOF_GONE  = 4'd7,
        EV_IGNORED   = 4'd8
    } event_t;

    typedef struct packed {
        logic [TimeoutW-1:0]  timeout_ticks;
        logic [AttemptsW-1:0] eof_attempts;
    } cfg_t;

    typedef struct packed {
        logic   ready_res;
        event_t event_res;
        logic   send_eof;
        logic   send_seq;
        logic   send_now;
    } result_t;

endpackage

// File: rtl/sws_cfg.sv
// ----------------------------------------------------------------------------
// sws_cfg
// APB register file holding the retransmit timeout and end-of-file attempts.
// ----------------------------------------------------------------------------
module sws_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sws_pkg::ApbAddrW-1:0]  paddr,
    input  logic [sws_pkg::ApbDataW-1:0]  pwdata,
    output logic [sws_pkg::ApbDataW-1:0]  prdata,
    output logic                          pready,
    output sws_pkg::cfg_t                 cfg
);
    import sws_pkg::*;

    cfg_t cfg_reg, cfg_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            if (paddr[2] == AddrAttempts[2]) begin
                cfg_next.eof_attempts = pwdata[AttemptsW-1:0];
            end else begin
                cfg_next.timeout_ticks = pwdata[TimeoutW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.timeout_ticks <= TimeoutReset;
            cfg_reg.eof_attempts  <= AttemptsReset;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        if (paddr[2] == AddrAttempts[2]) begin
            prdata = {{(ApbDataW-AttemptsW){1'b0}}, cfg_reg.eof_attempts};
        end else begin
            prdata = {{(ApbDataW-TimeoutW){1'b0}}, cfg_reg.timeout_ticks};
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/sws_ctrl.sv
// ----------------------------------------------------------------------------
// sws_ctrl
// Sender state and the single-pass step logic for one command beat.
// ----------------------------------------------------------------------------
module sws_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  sws_pkg::cmd_t     cmd,
    input  logic [7:0]        ack_byte,
    input  logic              ack_last,
    input  sws_pkg::cfg_t     cfg,
    output sws_pkg::result_t  res,
    output logic              seq_bit
);
    import sws_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_DATA = 3'b010,
        PH_EOF  = 3'b100
    } phase_t;

    phase_t               phase_reg, phase_next;
    logic                 seq_reg, seq_next;
    logic [TimeoutW-1:0]  timer_reg, timer_next;
    logic [AttemptsW-1:0] attempts_reg, attempts_next;
    logic [3:0]           pos_reg, pos_next;
    logic [7:0]           xor_reg, xor_next;
    logic [31:0]          cseq_reg, cseq_next;
    logic [31:0]          cchk_reg, cchk_next;

    logic                 busy;
    logic                 do_resend;
    event_t               resend_ev;
    logic [TimeoutW-1:0]  tmr_inc;
    logic [TimeoutW-1:0]  lim;
    logic [AttemptsW-1:0] n_att;
    logic [31:0]          byte_sh;
    logic [31:0]          chk;
    logic                 good;
    logic                 match;

    always_comb begin
        busy          = (phase_reg == PH_DATA) || (phase_reg == PH_EOF);
        phase_next    = busy ? phase_reg : PH_IDLE;
        seq_next      = seq_reg;
        timer_next    = timer_reg;
        attempts_next = attempts_reg;
        pos_next      = pos_reg;
        xor_next      = xor_reg;
        cseq_next     = cseq_reg;
        cchk_next     = cchk_reg;
        do_resend     = 1'b0;
        resend_ev     = EV_NONE;
        tmr_inc       = (timer_reg != {TimeoutW{1'b1}}) ? timer_reg + 1'b1 : timer_reg;
        lim           = (cfg.timeout_ticks == '0) ? TimeoutW'(1) : cfg.timeout_ticks;
        n_att         = (cfg.eof_attempts == '0) ? AttemptsW'(1) : cfg.eof_attempts;
        byte_sh       = {24'd0, ack_byte} << {pos_reg[1:0], 3'b000};
        chk           = '0;
        good          = 1'b0;
        match         = 1'b0;
        res           = '0;
        res.event_res = EV_NONE;

        case (cmd)
            CMD_DATA, CMD_EOF: begin
                if (busy) begin
                    res.event_res = EV_IGNORED;
                end else begin
                    phase_next = (cmd == CMD_DATA) ? PH_DATA : PH_EOF;
                    if (cmd == CMD_EOF) begin
                        attempts_next = n_att - 1'b1;
                        res.send_eof  = 1'b1;
                    end
                    timer_next    = '0;
                    pos_next      = '0;
                    xor_next      = '0;
                    cseq_next     = '0;
                    cchk_next     = '0;
                    res.send_now  = 1'b1;
                    res.send_seq  = seq_reg;
                    res.event_res = EV_FIRST;
                end
            end
            CMD_TICK: begin
                if (busy) begin
                    timer_next = tmr_inc;
                    if (tmr_inc >= lim) begin
                        do_resend = 1'b1;
                        resend_ev = EV_TIMEOUT;
                    end
                end
            end
            default: begin
                if (!busy) begin
                    pos_next      = '0;
                    xor_next      = '0;
                    cseq_next     = '0;
                    cchk_next     = '0;
                    res.event_res = EV_IGNORED;
                end else begin
                    if (pos_reg[3:2] == 2'b00) begin
                        cseq_next = cseq_reg | byte_sh;
                    end
                    if (pos_reg[3:2] == 2'b10) begin
                        cchk_next = cchk_reg | byte_sh;
                    end else begin
                        xor_next = xor_reg ^ ack_byte;
                    end
                    if (pos_reg != 4'hf) begin
                        pos_next = pos_reg + 1'b1;
                    end
                    if (ack_last) begin
                        chk       = {{24{xor_next[7]}}, xor_next};
                        good      = (chk == cchk_next);
                        match     = (cseq_next == {31'd0, seq_reg});
                        pos_next  = '0;
                        xor_next  = '0;
                        cseq_next = '0;
                        cchk_next = '0;
                        if (!good) begin
                            do_resend = 1'b1;
                            resend_ev = EV_BAD_CHECK;
                        end else if (!match) begin
                            do_resend = 1'b1;
                            resend_ev = EV_WRONG_SEQ;
                        end else if (phase_reg == PH_DATA) begin
                            seq_next      = ~seq_reg;
                            phase_next    = PH_IDLE;
                            res.event_res = EV_ACCEPTED;
                        end else begin
                            phase_next    = PH_IDLE;
                            res.event_res = EV_EOF_ACK;
                        end
                    end
                end
            end
        endcase

        // shared resend path, eof consumes one attempt or gives up
        if (do_resend) begin
            if ((phase_reg == PH_EOF) && (attempts_reg == '0)) begin
                phase_next    = PH_IDLE;
                res.event_res = EV_EOF_GONE;
            end else begin
                if (phase_reg == PH_EOF) begin
                    attempts_next = attempts_reg - 1'b1;
                    res.send_eof  = 1'b1;
                end
                timer_next    = '0;
                res.send_now  = 1'b1;
                res.send_seq  = seq_reg;
                res.event_res = resend_ev;
            end
        end

        res.ready_res = (phase_next == PH_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            seq_reg      <= 1'b0;
            timer_reg    <= '0;
            attempts_reg <= '0;
            pos_reg      <= '0;
            xor_reg      <= '0;
            cseq_reg     <= '0;
            cchk_reg     <= '0;
        end else if (step) begin
            phase_reg    <= phase_next;
            seq_reg      <= seq_next;
            timer_reg    <= timer_next;
            attempts_reg <= attempts_next;
            pos_reg      <= pos_next;
            xor_reg      <= xor_next;
            cseq_reg     <= cseq_next;
            cchk_reg     <= cchk_next;
        end
    end

    assign seq_bit = seq_reg;

endmodule

// File: rtl/stop_and_wait_sender.sv
// ----------------------------------------------------------------------------
// stop_and_wait_sender
// Alternating-bit stop-and-wait sender control with APB configuration.
// ----------------------------------------------------------------------------
// One command beat goes in, one result beat comes out. A beat is held in an
// input register, the step logic runs combinationally against the sender
// state, and the result lands in an output register, so the block takes one
// beat per cycle unless a waiting result and a full input register stall it.
// A waiting result only stops new beats once the input register is also full;
// with the result side ready the input is never held off. There is no
// clearing pass.
module stop_and_wait_sender (
    input  logic                          aclk,
    input  logic                          aresetn,
    // command beat
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,  // [7:0] ack_byte
    input  logic [1:0]                    s_tuser,  // [1:0] cmd
    input  logic                          s_tlast,  // ack_last
    // result beat
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] send_now, [1] send_seq, [2] send_eof, [6:3] event_res, [7] ready_res
    output logic [7:0]                    m_tdata,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sws_pkg::ApbAddrW-1:0]  paddr,
    input  logic [sws_pkg::ApbDataW-1:0]  pwdata,
    output logic [sws_pkg::ApbDataW-1:0]  prdata,
    output logic                          pready
);
    import sws_pkg::*;

    logic       in_valid_reg, in_valid_next;
    cmd_t       in_cmd_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       out_valid_reg, out_valid_next;
    result_t    out_res_reg;
    logic       advance;
    logic       take;
    cfg_t       cfg;
    result_t    res;
    logic       seq_bit;

    sws_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sws_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (advance),
        .cmd      (in_cmd_reg),
        .ack_byte (in_byte_reg),
        .ack_last (in_last_reg),
        .cfg      (cfg),
        .res      (res),
        .seq_bit  (seq_bit)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign take     = s_tvalid && s_tready;

    assign in_valid_next  = take || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            in_cmd_reg  <= cmd_t'(s_tuser);
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_res_reg.ready_res, out_res_reg.event_res, out_res_reg.send_eof,
                       out_res_reg.send_seq, out_res_reg.send_now};

    // an accepted acknowledgement flips the sequence bit
    a_accept_toggles: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (res.event_res == EV_ACCEPTED) |=> seq_bit != $past(seq_bit))
        else $error("sequence bit did not toggle on accept");

    // a new result only appears when the step logic fires
    a_result_from_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(advance))
        else $error("result valid without a step");

    // new beats are blocked only while the input register is stalled
    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input not ready without a stall");

endmodule

// File: tb/tb_stop_and_wait_sender.sv
// ----------------------------------------------------------------------------
// tb_stop_and_wait_sender
// Self-checking bench for the alternating-bit stop-and-wait sender control.
// Command, tick and acknowledgement beats are driven with random gaps while
// the result side stalls at random. Every accepted beat is run through a
// cycle-free model of the sender. Each result beat is compared field by field
// against the oldest predicted outcome. Directed runs cover idle commands,
// timeouts, checksum and sequence failures, short and long acknowledgements
// and end-of-file attempt limits. Random exchanges run under changing timeout
// and attempt settings, and one phase holds the result side off for a long
// stretch.
// ----------------------------------------------------------------------------
module tb_stop_and_wait_sender;
    timeunit 1ns;
    timeprecision 1ps;

    import sws_pkg::*;

    localparam int unsigned LimitCycles  = 250000;
    localparam int unsigned RandomBeats  = 950;
    localparam int unsigned LongHold     = 300;
    localparam int unsigned MaxPrinted   = 100;

    typedef enum logic [1:0] {
        LINK_IDLE     = 2'd0,
        LINK_DATA     = 2'd1,
        LINK_EOF      = 2'd2
    } link_phase_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata = '0;
    logic [1:0]           s_tuser = '0;
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [7:0]           m_tdata;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ApbAddrW-1:0]  paddr = '0;
    logic [ApbDataW-1:0]  pwdata = '0;
    logic [ApbDataW-1:0]  prdata;
    logic                 pready;

    stop_and_wait_sender dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // sender model state
    link_phase_t          link_phase = LINK_IDLE;
    logic                 cur_seq = 1'b0;
    logic [15:0]          tick_count = '0;
    logic [3:0]           eof_tries_left = '0;
    logic [3:0]           ack_pos = '0;
    logic [7:0]           ack_xor = '0;
    logic [31:0]          ack_seq_word = '0;
    logic [31:0]          ack_check_word = '0;
    logic [15:0]          cfg_timeout = TimeoutReset;
    logic [3:0]           cfg_eof_tries = AttemptsReset;

    result_t              pending_outcomes[$];
    result_t              seen_res;
    result_t              want_res;

    int unsigned          mismatches = 0;
    int unsigned          cycle_count = 0;
    int unsigned          beats_sent = 0;
    bit                   tx_idle_on = 1'b1;
    bit                   rx_idle_on = 1'b1;
    bit                   long_hold_req = 1'b0;

    initial begin
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LimitCycles) begin
            $display("timeout after %0d cycles, %0d outcomes pending", cycle_count,
                     pending_outcomes.size());
            $display("[stop_and_wait_sender] ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (mismatches < MaxPrinted)
            $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
                     cycle_count);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // sender model
    // ------------------------------------------------------------------------
    function automatic void clear_ack_capture();
        ack_pos = '0;
        ack_xor = '0;
        ack_seq_word = '0;
        ack_check_word = '0;
    endfunction

    function automatic void retransmit(inout result_t r, input event_t ev);
        if (link_phase == LINK_EOF) begin
            if (eof_tries_left == 4'd0) begin
                link_phase = LINK_IDLE;
                r.event_res = EV_EOF_GONE;
                return;
            end
            eof_tries_left = eof_tries_left - 4'd1;
            r.send_eof = 1'b1;
        end
        tick_count = '0;
        r.send_now = 1'b1;
        r.send_seq = cur_seq;
        r.event_res = ev;
    endfunction

    function automatic result_t advance_sender(input cmd_t c, input logic [7:0] b,
                                               input logic l);
        result_t     r;
        logic        busy;
        logic [15:0] lim;
        logic [3:0]  n;
        logic [3:0]  p;
        logic [31:0] chk;
        logic        good;
        logic        match;
        busy = (link_phase == LINK_DATA) || (link_phase == LINK_EOF);
        r = '0;
        r.event_res = EV_NONE;
        case (c)
            CMD_DATA, CMD_EOF: begin
                if (busy) begin
                    r.event_res = EV_IGNORED;
                end else begin
                    link_phase = (c == CMD_DATA) ? LINK_DATA : LINK_EOF;
                    if (c == CMD_EOF) begin
                        n = (cfg_eof_tries == 4'd0) ? 4'd1 : cfg_eof_tries;
                        eof_tries_left = n - 4'd1;
                        r.send_eof = 1'b1;
                    end
                    tick_count = '0;
                    clear_ack_capture();
                    r.send_now = 1'b1;
                    r.send_seq = cur_seq;
                    r.event_res = EV_FIRST;
                end
            end
            CMD_TICK: begin
                if (busy) begin
                    lim = (cfg_timeout == 16'd0) ? 16'd1 : cfg_timeout;
                    if (tick_count != 16'hFFFF)
                        tick_count = tick_count + 16'd1;
                    if (tick_count >= lim)
                        retransmit(r, EV_TIMEOUT);
                end
            end
            default: begin
                if (!busy) begin
                    clear_ack_capture();
                    r.event_res = EV_IGNORED;
                end else begin
                    p = ack_pos;
                    if (p < 4'd4)
                        ack_seq_word |= 32'(b) << (8 * p);
                    if (p >= 4'd8 && p < 4'd12)
                        ack_check_word |= 32'(b) << (8 * (p - 4'd8));
                    else
                        ack_xor ^= b;
                    if (ack_pos < 4'd15)
                        ack_pos = ack_pos + 4'd1;
                    if (l) begin
                        chk = {{24{ack_xor[7]}}, ack_xor};
                        good = (chk == ack_check_word);
                        match = (ack_seq_word == {31'b0, cur_seq});
                        clear_ack_capture();
                        if (!good) begin
                            retransmit(r, EV_BAD_CHECK);
                        end else if (!match) begin
                            retransmit(r, EV_WRONG_SEQ);
                        end else if (link_phase == LINK_DATA) begin
                            cur_seq = ~cur_seq;
                            link_phase = LINK_IDLE;
                            r.event_res = EV_ACCEPTED;
                        end else begin
                            link_phase = LINK_IDLE;
                            r.event_res = EV_EOF_ACK;
                        end
                    end
                end
            end
        endcase
        r.ready_res = (link_phase == LINK_IDLE);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------------
    initial begin
        int unsigned g;
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LongHold) @(negedge aclk);
            end else begin
                g = rx_idle_on ? $urandom_range(0, 10) : 0;
                if (g > 0) begin
                    m_tready <= 1'b0;
                    repeat (g) @(negedge aclk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && aresetn));
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen_res = result_t'(m_tdata);
            if (pending_outcomes.size() == 0) begin
                report_mismatch("result beat with nothing pending", 32'(m_tdata), 0);
            end else begin
                want_res = pending_outcomes.pop_front();
                if (seen_res.send_now !== want_res.send_now)
                    report_mismatch("send_now", 32'(seen_res.send_now),
                                    32'(want_res.send_now));
                if (seen_res.send_seq !== want_res.send_seq)
                    report_mismatch("send_seq", 32'(seen_res.send_seq),
                                    32'(want_res.send_seq));
                if (seen_res.send_eof !== want_res.send_eof)
                    report_mismatch("send_eof", 32'(seen_res.send_eof),
                                    32'(want_res.send_eof));
                if (seen_res.event_res !== want_res.event_res)
                    report_mismatch("event_res", 32'(seen_res.event_res),
                                    32'(want_res.event_res));
                if (seen_res.ready_res !== want_res.ready_res)
                    report_mismatch("ready_res", 32'(seen_res.ready_res),
                                    32'(want_res.ready_res));
            end
        end
    end

    // ------------------------------------------------------------------------
    // command side
    // ------------------------------------------------------------------------
    task automatic send_beat(input cmd_t c, input logic [7:0] b, input logic l);
        int unsigned g;
        g = tx_idle_on ? $urandom_range(0, 10) : 0;
        @(negedge aclk);
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= c;
        s_tlast <= l;
        do @(posedge aclk); while (!s_tready);
        pending_outcomes.push_back(advance_sender(c, b, l));
        beats_sent++;
    endtask

    task automatic send_noise(input int unsigned n);
        repeat (n) send_beat(cmd_t'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
    endtask

    // builds an acknowledgement with a valid checksum unless corrupted
    task automatic send_ack(input logic [31:0] seq_word, input int unsigned len,
                            input bit corrupt);
        logic [7:0]  pkt [0:19];
        logic [7:0]  x;
        logic [31:0] chk;
        int unsigned i;
        for (i = 0; i < 20; i++)
            pkt[i] = 8'($urandom);
        for (i = 0; i < 4; i++)
            pkt[i] = seq_word[8*i +: 8];
        x = '0;
        for (i = 0; i < len; i++)
            if (!(i >= 8 && i < 12))
                x ^= pkt[i];
        chk = {{24{x[7]}}, x};
        if (corrupt)
            chk ^= 32'd1 << $urandom_range(0, 31);
        for (i = 8; i < 12; i++)
            pkt[i] = chk[8*(i-8) +: 8];
        for (i = 0; i < len; i++)
            send_beat(CMD_ACK, pkt[i], i == len - 1);
    endtask

    task automatic drain_outcomes();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [ApbAddrW-1:0] addr, input logic [31:0] value);
        logic [31:0] want;
        drain_outcomes();
        want = (addr == AddrTimeout) ? {16'b0, value[15:0]} : {28'b0, value[3:0]};
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (addr == AddrTimeout)
            cfg_timeout = value[15:0];
        else
            cfg_eof_tries = value[3:0];
        @(negedge aclk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== want)
            report_mismatch("register readback", prdata, want);
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // one start command followed by ticks and replies until the sender idles or twenty rounds have run
    task automatic run_exchange(input cmd_t start);
        int unsigned rounds;
        int unsigned v;
        rounds = 0;
        send_beat(start, 8'($urandom), 1'($urandom));
        while (link_phase != LINK_IDLE && rounds < 20) begin
            rounds++;
            repeat ($urandom_range(0, 6)) send_beat(CMD_TICK, 8'($urandom), 1'($urandom));
            if (link_phase != LINK_IDLE) begin
                v = $urandom_range(0, 9);
                case (v)
                    6: send_ack($urandom_range(0, 1) ? {31'b0, ~cur_seq} : $urandom,
                                $urandom_range(12, 18), 1'b0);
                    7: send_ack({31'b0, cur_seq}, $urandom_range(12, 18), 1'b1);
                    8: send_ack($urandom, $urandom_range(1, 11), 1'($urandom));
                    9: send_noise($urandom_range(1, 5));
                    default: send_ack({31'b0, cur_seq}, $urandom_range(12, 20), 1'b0);
                endcase
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_idle_commands();
        send_beat(CMD_TICK, 8'h00, 1'b0);
        send_beat(CMD_ACK, 8'hFF, 1'b1);
        send_beat(CMD_ACK, 8'h00, 1'b0);
        send_beat(CMD_TICK, 8'hFF, 1'b1);
    endtask

    task automatic test_data_transfer();
        write_reg(AddrTimeout, 32'd3);
        send_beat(CMD_DATA, 8'hA5, 1'b0);
        send_beat(CMD_DATA, 8'h00, 1'b1);
        send_beat(CMD_EOF, 8'hFF, 1'b0);
        repeat (3) send_beat(CMD_TICK, 8'h5A, 1'b0);
        send_ack({31'b0, cur_seq}, 12, 1'b0);
        send_beat(CMD_DATA, 8'h00, 1'b0);
        send_ack({31'b0, ~cur_seq}, 12, 1'b0);
        send_ack({31'b0, cur_seq}, 12, 1'b1);
        send_ack({31'b0, cur_seq}, 3, 1'b0);
        send_ack({31'b0, cur_seq}, 20, 1'b0);
    endtask

    task automatic test_eof_transfer();
        write_reg(AddrAttempts, 32'd2);
        send_beat(CMD_EOF, 8'h00, 1'b0);
        send_ack({31'b0, cur_seq}, 12, 1'b1);
        send_ack({31'b0, ~cur_seq}, 12, 1'b0);
        send_beat(CMD_EOF, 8'h00, 1'b0);
        send_ack({31'b0, cur_seq}, 12, 1'b0);
        write_reg(AddrAttempts, 32'd0);
        write_reg(AddrTimeout, 32'd1);
        send_beat(CMD_EOF, 8'h00, 1'b0);
        send_beat(CMD_TICK, 8'h00, 1'b0);
        write_reg(AddrAttempts, 32'd15);
        write_reg(AddrTimeout, 32'd0);
        send_beat(CMD_EOF, 8'h00, 1'b0);
        repeat (17) send_beat(CMD_TICK, 8'h00, 1'b0);
    endtask

    task automatic test_timeout_settings();
        write_reg(AddrTimeout, 32'd65535);
        send_beat(CMD_DATA, 8'h00, 1'b0);
        repeat (12) send_beat(CMD_TICK, 8'h00, 1'b0);
        send_ack({31'b0, cur_seq}, 12, 1'b0);
        write_reg(AddrTimeout, 32'hFFFF_0002);
        run_exchange(CMD_DATA);
    endtask

    task automatic test_backpressure();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        long_hold_req = 1'b1;
        send_noise(40);
        run_exchange(CMD_DATA);
        drain_outcomes();
        run_exchange(CMD_EOF);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        int unsigned start;
        int unsigned last_cfg;
        int unsigned kind;
        start = beats_sent;
        last_cfg = beats_sent;
        while (beats_sent - start < RandomBeats) begin
            if (beats_sent - last_cfg > 250) begin
                last_cfg = beats_sent;
                case ($urandom_range(0, 3))
                    0: write_reg(AddrTimeout, 32'd0);
                    1: write_reg(AddrTimeout, 32'd65535);
                    default: write_reg(AddrTimeout, $urandom_range(1, 8));
                endcase
                write_reg(AddrAttempts, $urandom_range(0, 15));
            end
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            kind = $urandom_range(0, 9);
            if (kind <= 5)
                run_exchange(CMD_DATA);
            else if (kind <= 7)
                run_exchange(CMD_EOF);
            else
                send_noise($urandom_range(1, 8));
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_idle_commands();
        test_data_transfer();
        test_eof_transfer();
        test_timeout_settings();
        test_backpressure();
        test_random_traffic();
        drain_outcomes();
        repeat (10) @(posedge aclk);
        if (mismatches == 0)
            $display("[stop_and_wait_sender] OK");
        else
            $display("[stop_and_wait_sender] ERROR");
        $finish;
    end

endmodule
